// ===== hw/rtl/lcd_line_mode_sequencer_top_assert.svh =====
// ----------------------------------------------------------------------------
// LCD line mode sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_LINE_MODE_SEQUENCER_TOP_ASSERT_SVH
`define LCD_LINE_MODE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define LMS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lms_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD line mode sequencer package
// Payload types, mode and source codes, and default line counts.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int LINE_W          = 8;
    localparam int SRC_W           = 4;
    localparam int VISIBLE_LINES_D = 144;
    localparam int TOTAL_LINES_D   = 154;

    localparam logic REQ_ADVANCE   = 1'b0;
    localparam logic REQ_WRITE_CMP = 1'b1;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam int SRC_HBLANK = 0;
    localparam int SRC_VBLANK = 1;
    localparam int SRC_OAM    = 2;
    localparam int SRC_CMP    = 3;

    typedef enum logic [3:0] {
        ST_HBLANK = 4'b0001,
        ST_VBLANK = 4'b0010,
        ST_OAM    = 4'b0100,
        ST_DRAW   = 4'b1000
    } mode_state_t;

    typedef struct packed {
        logic              req_type;
        logic [LINE_W-1:0] compare_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        display_mode;
        logic [LINE_W-1:0] current_line;
        logic              line_match;
        logic              vblank_request;
        logic              status_request;
    } out_item_t;

    typedef struct packed {
        logic              step_en;
        logic [SRC_W-1:0]  enables;
    } step_ctrl_t;

    function automatic logic [1:0] mode_code(input mode_state_t s);
        logic [1:0] code;
        unique case (s)
            ST_HBLANK: code = MODE_HBLANK;
            ST_VBLANK: code = MODE_VBLANK;
            ST_OAM:    code = MODE_OAM;
            ST_DRAW:   code = MODE_DRAW;
            default:   code = MODE_OAM;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/lms_step_core.sv =====
// ----------------------------------------------------------------------------
// LCD line mode sequencer step core
// Holds mode, line, compare and source state; computes one transaction's
// result from the registered input and commits the state on step_en.
// ----------------------------------------------------------------------------
`include "lcd_line_mode_sequencer_top_assert.svh"

module lms_step_core
    import lms_pkg::*;
#(
    parameter int VISIBLE_LINES = VISIBLE_LINES_D,
    parameter int TOTAL_LINES   = TOTAL_LINES_D
) (
    input  logic       clk,
    input  logic       rst_n,
    input  step_ctrl_t ctrl,
    input  in_item_t   item,
    output out_item_t  result
);

    localparam logic [LINE_W-1:0] VIS_LINE = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0] TOT_LINE = LINE_W'(TOTAL_LINES);

    mode_state_t       mode_reg, mode_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W-1:0] compare_reg, compare_next;
    logic              match_flag_reg, match_flag_next;
    logic [SRC_W-1:0]  source_bits_reg, source_bits_next;
    logic              vblank_req;
    logic [LINE_W-1:0] line_inc;

    always_comb
    begin
        mode_next        = mode_reg;
        line_next        = line_reg;
        compare_next     = compare_reg;
        match_flag_next  = match_flag_reg;
        source_bits_next = source_bits_reg;
        vblank_req       = 1'b0;
        line_inc         = line_reg + LINE_W'(1);

        if (item.req_type == REQ_WRITE_CMP)
        begin
            compare_next = item.compare_value;
        end
        else
        begin
            unique case (mode_reg)
                ST_HBLANK:
                begin
                    line_next = line_inc;
                    source_bits_next[SRC_HBLANK] = 1'b0;
                    if (line_inc == VIS_LINE)
                    begin
                        mode_next  = ST_VBLANK;
                        vblank_req = 1'b1;
                        source_bits_next[SRC_VBLANK] = ctrl.enables[SRC_VBLANK]
                                                     | source_bits_reg[SRC_VBLANK];
                    end
                    else
                    begin
                        mode_next = ST_OAM;
                        source_bits_next[SRC_OAM] = ctrl.enables[SRC_OAM]
                                                  | source_bits_reg[SRC_OAM];
                    end
                end
                ST_VBLANK:
                begin
                    line_next = line_inc;
                    if (line_inc == TOT_LINE)
                    begin
                        line_next = '0;
                        mode_next = ST_OAM;
                        source_bits_next[SRC_VBLANK] = 1'b0;
                        source_bits_next[SRC_OAM] = ctrl.enables[SRC_OAM]
                                                  | source_bits_reg[SRC_OAM];
                    end
                end
                ST_OAM:
                begin
                    mode_next = ST_DRAW;
                    source_bits_next[SRC_OAM] = 1'b0;
                end
                ST_DRAW:
                begin
                    mode_next = ST_HBLANK;
                    source_bits_next[SRC_HBLANK] = ctrl.enables[SRC_HBLANK]
                                                 | source_bits_reg[SRC_HBLANK];
                end
                default:
                begin
                    mode_next = ST_OAM;
                end
            endcase
        end

        // line compare; held unchanged while oam scan or drawing advances
        if (item.req_type == REQ_WRITE_CMP || mode_reg == ST_HBLANK
            || mode_reg == ST_VBLANK)
        begin
            match_flag_next = (line_next == compare_next);
            // a line step clears the compare source before the new compare
            if (item.req_type == REQ_WRITE_CMP)
            begin
                source_bits_next[SRC_CMP] = match_flag_next
                    & (ctrl.enables[SRC_CMP] | source_bits_reg[SRC_CMP]);
            end
            else
            begin
                source_bits_next[SRC_CMP] = match_flag_next & ctrl.enables[SRC_CMP];
            end
        end

        result.display_mode   = mode_code(mode_next);
        result.current_line   = line_next;
        result.line_match     = match_flag_next;
        result.vblank_request = vblank_req;
        result.status_request = (source_bits_reg == '0) && (source_bits_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= ST_OAM;
            line_reg        <= '0;
            compare_reg     <= '0;
            match_flag_reg  <= 1'b1;
            source_bits_reg <= '0;
        end
        else if (ctrl.step_en)
        begin
            mode_reg        <= mode_next;
            line_reg        <= line_next;
            compare_reg     <= compare_next;
            match_flag_reg  <= match_flag_next;
            source_bits_reg <= source_bits_next;
        end
    end

    `LMS_ASSERT_IMPL(a_match_consistent, 1'b1,
        match_flag_reg == (line_reg == compare_reg), "match flag out of sync with line")
    `LMS_ASSERT_IMPL(a_vblank_req_mode, ctrl.step_en && result.vblank_request,
        result.display_mode == MODE_VBLANK, "vblank request outside vblank entry")
    `LMS_ASSERT_IMPL(a_status_from_zero, ctrl.step_en && result.status_request,
        source_bits_reg == '0, "status request with sources already active")
    `LMS_ASSERT_NEXT(a_write_keeps_timing, ctrl.step_en && item.req_type == REQ_WRITE_CMP,
        $stable(line_reg) && $stable(mode_reg), "compare write moved mode or line")

endmodule

// ===== hw/rtl/lcd_line_mode_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// LCD line mode sequencer top level
// Input register, step core and result register with valid/ready channels.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock cycle while the output is not stalled; a
// transaction is held in the input register until the result register is free
// or being emptied, then its result is captured in the result register and
// offered on the output until out_ready takes it. The step core works out mode,
// line and source state between the two registers and commits it as the
// transaction moves on. The source enable register is written over the cfg
// channel, which is always ready.

module lcd_line_mode_sequencer_top
    import lms_pkg::*;
#(
    parameter int VISIBLE_LINES = VISIBLE_LINES_D,
    parameter int TOTAL_LINES   = TOTAL_LINES_D
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [SRC_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic [SRC_W-1:0] enables_reg;
    logic             advance;
    step_ctrl_t       ctrl;
    out_item_t        step_result;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign ctrl.step_en = advance;
    assign ctrl.enables = enables_reg;

    lms_step_core #(
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (in_item_reg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            enables_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                enables_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

endmodule
